[rtl/lcet_pkg.sv]
// ----------------------------------------------------------------------------
// lcet_pkg: shared types and constants of the level-crossing edge timer
// Field widths, derived arithmetic widths, register indexes and the job
// record that travels from the classifier front end to the timing back end.
// ----------------------------------------------------------------------------
package lcet_pkg;

	// Field widths.
	localparam int TIME_BITS  = 48;
	localparam int VALUE_BITS = 32;

	// Configuration port data width: the widest register.
	localparam int CFG_BITS = (TIME_BITS > VALUE_BITS) ? TIME_BITS : VALUE_BITS;

	// Stream data widths, rounded up to whole bytes.
	localparam int S_TDATA_BITS = ((TIME_BITS + VALUE_BITS + 7) / 8) * 8;
	localparam int M_TDATA_BITS = ((TIME_BITS + 7) / 8) * 8;

	// The time difference is multiplied in two halves.
	localparam int HI_BITS       = TIME_BITS / 2;
	localparam int LO_BITS       = TIME_BITS - HI_BITS;
	localparam int LO_PROD_BITS  = VALUE_BITS + LO_BITS;
	localparam int HI_PROD_BITS  = VALUE_BITS + HI_BITS;
	localparam int PROD_BITS     = VALUE_BITS + TIME_BITS;

	// Radix-16 restoring divider: four quotient bits per cycle.
	localparam int DIV_STEP     = 4;
	localparam int DIV_CYCLES   = (TIME_BITS + DIV_STEP - 1) / DIV_STEP;
	localparam int QUO_BITS     = DIV_CYCLES * DIV_STEP;
	localparam int QUO_PAD      = QUO_BITS - TIME_BITS;
	localparam int DIV_CNT_BITS = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;

	// Job queue between front and back; depth is a power of two.
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

	// Configuration register indexes.
	typedef enum logic [1:0] {
		REG_LEVEL     = 2'd0,
		REG_WIN_BEGIN = 2'd1,
		REG_WIN_END   = 2'd2,
		REG_GATE_MODE = 2'd3
	} cfg_reg_t;

	// Current configuration as seen by both halves.
	typedef struct packed {
		logic signed [VALUE_BITS-1:0] level;
		logic [TIME_BITS-1:0]         win_begin;
		logic [TIME_BITS-1:0]         win_end;
		logic                         gate_mode;
	} cfg_t;

	// One crossing to be timed.
	typedef struct packed {
		logic [TIME_BITS-1:0]  t0;
		logic [TIME_BITS-1:0]  t1;
		logic [TIME_BITS-1:0]  dt;
		logic [VALUE_BITS-1:0] num;
		logic [VALUE_BITS-1:0] den;
		logic                  rise;
		logic                  interp;
	} job_t;

	// Front end to queue.
	typedef struct packed {
		logic push;
		job_t job;
	} front_push_t;

	// Queue status toward both ends.
	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

endpackage

[rtl/level_crossing_edge_timer.sv]
// A gate-mode crossing is loaded from the job queue and then offered on the edge stream; an analog
// crossing first passes the two multiply halves, the sum, the divider and the final add.
// Samples that raise no crossing job are taken one per cycle while the job queue is not full; each
// crossing occupies the interpolator from its load until its edge is offered or dropped, and longer
// while the edge stream stalls. A two-entry job queue decouples the two ends.
// Reset (arst_n low) clears the previous sample, the queue and the output, and loads defaults.
// ----------------------------------------------------------------------------
// level_crossing_edge_timer: level-crossing edge timer
// Detects crossings of a programmable level in a stream of timed samples and
// reports each crossing time, interpolated or sampled, within a time window.
// ----------------------------------------------------------------------------
module level_crossing_edge_timer
	import lcet_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	// Configuration write port
	input  logic                    cfg_we,
	input  logic [1:0]              cfg_index,
	input  logic [CFG_BITS-1:0]     cfg_data,
	// Sample stream
	input  logic                    s_tvalid,
	output logic                    s_tready,
	input  logic [S_TDATA_BITS-1:0] s_tdata,   // sample_time, sample_value
	input  logic                    s_tuser,   // first
	// Edge stream
	output logic                    m_tvalid,
	input  logic                    m_tready,
	output logic [M_TDATA_BITS-1:0] m_tdata,   // edge_time
	output logic                    m_tuser    // rising
);

	logic signed [VALUE_BITS-1:0] level_q;
	logic [TIME_BITS-1:0]         win_begin_q;
	logic [TIME_BITS-1:0]         win_end_q;
	logic                         gate_mode_q;

	cfg_t                 cfg;
	front_push_t          fpush;
	queue_status_t        qstat;
	job_t                 head;
	logic                 pop;
	logic [TIME_BITS-1:0] edge_time;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q     <= '0;
			win_begin_q <= '0;
			win_end_q   <= '1;
			gate_mode_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_LEVEL:     level_q     <= signed'(cfg_data[VALUE_BITS-1:0]);
				REG_WIN_BEGIN: win_begin_q <= cfg_data[TIME_BITS-1:0];
				REG_WIN_END:   win_end_q   <= cfg_data[TIME_BITS-1:0];
				REG_GATE_MODE: gate_mode_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign cfg.level     = level_q;
	assign cfg.win_begin = win_begin_q;
	assign cfg.win_end   = win_end_q;
	assign cfg.gate_mode = gate_mode_q;

	lcet_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.qstat    (qstat),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.fpush    (fpush)
	);

	lcet_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.fpush  (fpush),
		.pop    (pop),
		.qstat  (qstat),
		.head   (head)
	);

	lcet_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.qstat     (qstat),
		.head      (head),
		.pop       (pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.edge_time (edge_time),
		.rising    (m_tuser)
	);

	assign m_tdata = M_TDATA_BITS'(edge_time);

	// The queue is never written while full nor read while empty.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(fpush.push && qstat.full))
		else $error("crossing job pushed into a full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && qstat.empty))
		else $error("crossing job popped from an empty queue");

	// A reported edge always lies inside the window.
	a_edge_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (edge_time >= win_begin_q) && (edge_time <= win_end_q))
		else $error("reported edge time outside the window");

endmodule

[rtl/lcet_front.sv]
// ----------------------------------------------------------------------------
// lcet_front: sample classifier
// Keeps the previous sample, detects rising and falling level crossings inside
// the time window and hands each crossing to the job queue.
// ----------------------------------------------------------------------------
module lcet_front
	import lcet_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  cfg_t                    cfg,
	input  queue_status_t           qstat,
	input  logic                    s_tvalid,
	output logic                    s_tready,
	input  logic [S_TDATA_BITS-1:0] s_tdata,  // sample_time, sample_value
	input  logic                    s_tuser,  // first
	output front_push_t             fpush
);

	logic [TIME_BITS-1:0]         prev_time_q;
	logic signed [VALUE_BITS-1:0] prev_value_q;
	logic                         have_prev_q;

	logic [TIME_BITS-1:0]         t1;
	logic signed [VALUE_BITS-1:0] v1;
	logic                         accept;
	logic                         had;
	logic                         win_ok;
	logic                         rise;
	logic                         fall;
	logic signed [VALUE_BITS:0]   d_lv;
	logic signed [VALUE_BITS:0]   d_vl;
	logic signed [VALUE_BITS:0]   d_10;
	logic signed [VALUE_BITS:0]   d_01;

	// Items are taken whenever the queue has room for a possible crossing.
	assign s_tready = !qstat.full;
	assign accept   = s_tvalid && s_tready;

	// Classify the incoming sample against the stored one.
	always_comb begin
		t1     = s_tdata[TIME_BITS-1:0];
		v1     = signed'(s_tdata[TIME_BITS +: VALUE_BITS]);
		had    = have_prev_q && !s_tuser;
		win_ok = (cfg.win_begin <= cfg.win_end) && (t1 >= cfg.win_begin)
			&& (t1 <= cfg.win_end);
		rise   = (prev_value_q < cfg.level) && (v1 >= cfg.level);
		fall   = (prev_value_q >= cfg.level) && (v1 < cfg.level);
		d_lv   = {cfg.level[VALUE_BITS-1], cfg.level} - {prev_value_q[VALUE_BITS-1], prev_value_q};
		d_vl   = {prev_value_q[VALUE_BITS-1], prev_value_q} - {cfg.level[VALUE_BITS-1], cfg.level};
		d_10   = {v1[VALUE_BITS-1], v1} - {prev_value_q[VALUE_BITS-1], prev_value_q};
		d_01   = {prev_value_q[VALUE_BITS-1], prev_value_q} - {v1[VALUE_BITS-1], v1};

		fpush.push       = accept && had && win_ok && (rise || fall);
		fpush.job.t0     = prev_time_q;
		fpush.job.t1     = t1;
		fpush.job.dt     = t1 - prev_time_q;
		fpush.job.num    = rise ? d_lv[VALUE_BITS-1:0] : d_vl[VALUE_BITS-1:0];
		fpush.job.den    = rise ? d_10[VALUE_BITS-1:0] : d_01[VALUE_BITS-1:0];
		fpush.job.rise   = rise;
		// Time going backwards reports the current sample time.
		fpush.job.interp = !cfg.gate_mode && (t1 >= prev_time_q);
	end

	// Every accepted sample becomes the predecessor of the next one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_time_q  <= '0;
			prev_value_q <= '0;
			have_prev_q  <= 1'b0;
		end else if (accept) begin
			prev_time_q  <= t1;
			prev_value_q <= v1;
			have_prev_q  <= 1'b1;
		end
	end

endmodule

[rtl/lcet_queue.sv]
// ----------------------------------------------------------------------------
// lcet_queue: crossing job queue
// Small first-in first-out buffer that decouples the classifier from the
// interpolating back end.
// ----------------------------------------------------------------------------
module lcet_queue
	import lcet_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  front_push_t   fpush,
	input  logic          pop,
	output queue_status_t qstat,
	output job_t          head
);

	job_t                 mem_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0] wr_q;
	logic [QPTR_BITS-1:0] rd_q;
	logic [QPTR_BITS:0]   count_q;

	assign qstat.full  = (count_q == (QPTR_BITS+1)'(QUEUE_DEPTH));
	assign qstat.empty = (count_q == '0);
	assign head        = mem_q[rd_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (fpush.push) begin
			mem_q[wr_q] <= fpush.job;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (fpush.push) begin
				wr_q <= wr_q + QPTR_BITS'(1);
			end
			if (pop) begin
				rd_q <= rd_q + QPTR_BITS'(1);
			end
			if (fpush.push && !pop) begin
				count_q <= count_q + (QPTR_BITS+1)'(1);
			end else if (pop && !fpush.push) begin
				count_q <= count_q - (QPTR_BITS+1)'(1);
			end
		end
	end

endmodule

[rtl/lcet_back.sv]
// ----------------------------------------------------------------------------
// lcet_back: crossing time interpolator
// For interpolated jobs, multiplies the level offset by the time step in two halves
// and divides by the value step four quotient bits per cycle; for every job it applies
// the window and drives the registered result stream.
// ----------------------------------------------------------------------------
module lcet_back
	import lcet_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  cfg_t                 cfg,
	input  queue_status_t        qstat,
	input  job_t                 head,
	output logic                 pop,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [TIME_BITS-1:0] edge_time,
	output logic                 rising
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL_LO,
		ST_MUL_HI,
		ST_ACC,
		ST_DIV,
		ST_SUM,
		ST_FIN
	} state_t;

	state_t                  state_q;
	job_t                    job_q;
	logic [LO_PROD_BITS-1:0] pp_lo_q;
	logic [HI_PROD_BITS-1:0] pp_hi_q;
	logic [VALUE_BITS-1:0]   rem_q;
	logic [QUO_BITS-1:0]     dvd_q;
	logic [DIV_CNT_BITS-1:0] cnt_q;
	logic [TIME_BITS-1:0]    time_q;
	logic                    m_valid_q;
	logic [TIME_BITS-1:0]    edge_q;
	logic                    rise_q;

	logic [LO_PROD_BITS-1:0] pp_lo;
	logic [HI_PROD_BITS-1:0] pp_hi;
	logic [PROD_BITS-1:0]    prod;
	logic [VALUE_BITS-1:0]   rem;
	logic [QUO_BITS-1:0]     dvd;
	logic [VALUE_BITS:0]     trial;
	logic                    in_win;
	logic                    out_free;
	logic                    emit;

	assign pop       = (state_q == ST_IDLE) && !qstat.empty;
	assign m_tvalid  = m_valid_q;
	assign edge_time = edge_q;
	assign rising    = rise_q;
	assign out_free  = !m_valid_q || m_tready;
	assign in_win    = (time_q >= cfg.win_begin) && (time_q <= cfg.win_end);
	assign emit      = (state_q == ST_FIN) && in_win && out_free;

	// Partial products of offset times time step, and their sum.
	always_comb begin
		pp_lo = LO_PROD_BITS'(job_q.num) * LO_PROD_BITS'(job_q.dt[LO_BITS-1:0]);
		pp_hi = HI_PROD_BITS'(job_q.num) * HI_PROD_BITS'(job_q.dt[TIME_BITS-1:LO_BITS]);
		prod  = PROD_BITS'(pp_lo_q) + (PROD_BITS'(pp_hi_q) << LO_BITS);
	end

	// Four restoring division steps; quotient bits shift in behind the dividend.
	always_comb begin
		rem   = rem_q;
		dvd   = dvd_q;
		trial = '0;
		for (int i = 0; i < DIV_STEP; i++) begin
			trial = {rem, dvd[QUO_BITS-1]};
			dvd   = {dvd[QUO_BITS-2:0], 1'b0};
			if (trial >= {1'b0, job_q.den}) begin
				trial  = trial - {1'b0, job_q.den};
				dvd[0] = 1'b1;
			end
			rem = trial[VALUE_BITS-1:0];
		end
	end

	// Sequencer with the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			job_q     <= '0;
			pp_lo_q   <= '0;
			pp_hi_q   <= '0;
			rem_q     <= '0;
			dvd_q     <= '0;
			cnt_q     <= '0;
			time_q    <= '0;
			m_valid_q <= 1'b0;
			edge_q    <= '0;
			rise_q    <= 1'b0;
		end else begin
			// The output holds an edge from its load until its transfer.
			if (emit) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (!qstat.empty) begin
						job_q  <= head;
						time_q <= head.t1;
						state_q <= head.interp ? ST_MUL_LO : ST_FIN;
					end
				end
				ST_MUL_LO: begin
					pp_lo_q <= pp_lo;
					state_q <= ST_MUL_HI;
				end
				ST_MUL_HI: begin
					pp_hi_q <= pp_hi;
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					// The high part is below the divisor since the quotient fits the time width.
					rem_q   <= prod[PROD_BITS-1:TIME_BITS];
					dvd_q   <= QUO_BITS'(prod[TIME_BITS-1:0]) << QUO_PAD;
					cnt_q   <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					rem_q <= rem;
					dvd_q <= dvd;
					cnt_q <= cnt_q + DIV_CNT_BITS'(1);
					if (cnt_q == DIV_CNT_BITS'(DIV_CYCLES - 1)) begin
						state_q <= ST_SUM;
					end
				end
				ST_SUM: begin
					time_q  <= job_q.t0 + TIME_BITS'(dvd_q >> QUO_PAD);
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (!in_win) begin
						state_q <= ST_IDLE;
					end else if (out_free) begin
						edge_q  <= time_q;
						rise_q  <= job_q.rise;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

[verif/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the level-crossing edge timer
// A short table of hand-picked samples and register writes comes first. It is
// followed by random records, either well formed or broken, run under a
// dozen register settings. An in-bench model times each crossing, and every
// edge transfer is checked against it in order.
// ----------------------------------------------------------------------------
module testbench;
	import lcet_pkg::*;

	localparam logic [TIME_BITS-1:0]  T_MAX = {TIME_BITS{1'b1}};
	localparam logic [VALUE_BITS-1:0] V_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
	localparam logic [VALUE_BITS-1:0] V_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};
	localparam longint V_HI = 64'sd2147483647;
	localparam longint V_LO = -64'sd2147483648;

	// A queued crossing may still sit in the divider when the last edge leaves.
	localparam int SETTLE_CYCLES = 64;
	localparam int HOLD_CYCLES   = 300;
	localparam int SETTINGS_N    = 12;
	localparam int ITEMS_PER     = 84;
	localparam int HOLD_SETTING  = 9;
	// Slowest run is about 1100 analog crossings, each with the longest send and receive gaps.
	localparam int LIMIT_CYCLES  = 400000;

	typedef enum bit {ROW_SAMPLE, ROW_WRITE} row_kind_e;

	// One directed step: a sample, or a register write carried in the time field.
	typedef struct packed {
		row_kind_e              kind;
		cfg_reg_t               idx;
		logic [TIME_BITS-1:0]   t;
		logic [VALUE_BITS-1:0]  v;
		logic                   first;
		logic                   typed;
		logic                   hit;
		logic [TIME_BITS-1:0]   et;
		logic                   up;
	} dir_row_t;

	typedef struct packed {
		logic [TIME_BITS-1:0] when;
		logic                 up;
	} crossing_t;

	// Directed table: typed rows carry their edge, the rest go through the model.
	localparam dir_row_t DIR_TAB [0:34] = '{
		'{ROW_SAMPLE, REG_LEVEL, 48'd0, V_MIN, 1'b1, 1'b1, 1'b0, 48'd0, 1'b0},
		'{ROW_SAMPLE, REG_LEVEL, 48'd100, V_MAX, 1'b0, 1'b0, 1'b0, 48'd0, 1'b0},
		'{ROW_SAMPLE, REG_LEVEL, 48'd200, 32'd0, 1'b0, 1'b1, 1'b0, 48'd0, 1'b0},
		'{ROW_SAMPLE, REG_LEVEL, 48'd300, 32'hFFFF_FFFF, 1'b0, 1'b1, 1'b1, 48'd200, 1'b0},
		'{ROW_SAMPLE, REG_LEVEL, 48'd300, 32'd0, 1'b0, 1'b1, 1'b1, 48'd300, 1'b1},
		'{ROW_SAMPLE, REG_LEVEL, 48'd400, 32'hFFFF_FFFB, 1'b1, 1'b1, 1'b0, 48'd0, 1'b0},
		'{ROW_SAMPLE, REG_LEVEL, 48'd350, 32'd5, 1'b0, 1'b1, 1'b1, 48'd350, 1'b1},
		'{ROW_SAMPLE, REG_LEVEL, T_MAX, V_MIN, 1'b0, 1'b0, 1'b0, 48'd0, 1'b0},
		'{ROW_SAMPLE, REG_LEVEL, T_MAX, V_MAX, 1'b0, 1'b1, 1'b1, T_MAX, 1'b1},
		'{ROW_WRITE, REG_GATE_MODE, 48'd1, 32'd0, 1'b0, 1'b0, 1'b0, 48'd0, 1'b0},
		'{ROW_WRITE, REG_LEVEL, 48'd1, 32'd0, 1'b0, 1'b0, 1'b0, 48'd0, 1'b0},
		'{ROW_SAMPLE, REG_LEVEL, 48'd0, 32'd0, 1'b1, 1'b1, 1'b0, 48'd0, 1'b0},
		'{ROW_SAMPLE, REG_LEVEL, 48'd10, 32'd1, 1'b0, 1'b1, 1'b1, 48'd10, 1'b1},
		'{ROW_SAMPLE, REG_LEVEL, 48'd20, 32'd0, 1'b0, 1'b1, 1'b1, 48'd20, 1'b0},
		'{ROW_SAMPLE, REG_LEVEL, 48'd5, 32'd1, 1'b0, 1'b1, 1'b1, 48'd5, 1'b1},
		'{ROW_WRITE, REG_GATE_MODE, 48'd0, 32'd0, 1'b0, 1'b0, 1'b0, 48'd0, 1'b0},
		'{ROW_WRITE, REG_LEVEL, 48'd0, 32'd0, 1'b0, 1'b0, 1'b0, 48'd0, 1'b0},
		'{ROW_WRITE, REG_WIN_BEGIN, 48'd1000, 32'd0, 1'b0, 1'b0, 1'b0, 48'd0, 1'b0},
		'{ROW_WRITE, REG_WIN_END, 48'd2000, 32'd0, 1'b0, 1'b0, 1'b0, 48'd0, 1'b0},
		'{ROW_SAMPLE, REG_LEVEL, 48'd900, 32'hFFFF_FFF6, 1'b1, 1'b1, 1'b0, 48'd0, 1'b0},
		'{ROW_SAMPLE, REG_LEVEL, 48'd1100, 32'd10, 1'b0, 1'b0, 1'b0, 48'd0, 1'b0},
		'{ROW_SAMPLE, REG_LEVEL, 48'd1200, 32'hFFFF_FFE2, 1'b0, 1'b0, 1'b0, 48'd0, 1'b0},
		'{ROW_SAMPLE, REG_LEVEL, 48'd2100, 32'd30, 1'b0, 1'b1, 1'b0, 48'd0, 1'b0},
		'{ROW_SAMPLE, REG_LEVEL, 48'd2000, 32'hFFFF_FFE2, 1'b0, 1'b1, 1'b1, 48'd2000, 1'b0},
		'{ROW_SAMPLE, REG_LEVEL, 48'd500, 32'hFFFF_FFF6, 1'b1, 1'b1, 1'b0, 48'd0, 1'b0},
		'{ROW_SAMPLE, REG_LEVEL, 48'd1010, 32'd10, 1'b0, 1'b0, 1'b0, 48'd0, 1'b0},
		'{ROW_WRITE, REG_WIN_BEGIN, 48'd2001, 32'd0, 1'b0, 1'b0, 1'b0, 48'd0, 1'b0},
		'{ROW_SAMPLE, REG_LEVEL, 48'd2000, 32'hFFFF_FFF6, 1'b0, 1'b1, 1'b0, 48'd0, 1'b0},
		'{ROW_WRITE, REG_WIN_BEGIN, 48'd0, 32'd0, 1'b0, 1'b0, 1'b0, 48'd0, 1'b0},
		'{ROW_WRITE, REG_WIN_END, T_MAX, 32'd0, 1'b0, 1'b0, 1'b0, 48'd0, 1'b0},
		'{ROW_WRITE, REG_LEVEL, {16'd0, V_MAX}, 32'd0, 1'b0, 1'b0, 1'b0, 48'd0, 1'b0},
		'{ROW_SAMPLE, REG_LEVEL, 48'd5, 32'd0, 1'b0, 1'b1, 1'b0, 48'd0, 1'b0},
		'{ROW_SAMPLE, REG_LEVEL, 48'd9, V_MAX, 1'b0, 1'b0, 1'b0, 48'd0, 1'b0},
		'{ROW_WRITE, REG_LEVEL, {16'd0, V_MIN}, 32'd0, 1'b0, 1'b0, 1'b0, 48'd0, 1'b0},
		'{ROW_SAMPLE, REG_LEVEL, 48'd12, V_MIN, 1'b0, 1'b1, 1'b0, 48'd0, 1'b0}
	};

	logic                    clk;
	logic                    arst_n;
	logic                    cfg_we;
	logic [1:0]              cfg_index;
	logic [CFG_BITS-1:0]     cfg_data;
	logic                    s_tvalid;
	logic                    s_tready;
	logic [S_TDATA_BITS-1:0] s_tdata;   // sample_time, sample_value
	logic                    s_tuser;   // first
	logic                    m_tvalid;
	logic                    m_tready;
	logic [M_TDATA_BITS-1:0] m_tdata;   // edge_time
	logic                    m_tuser;   // rising

	// Model copy of the registers and of the stored sample.
	logic signed [VALUE_BITS-1:0] cur_level;
	logic [TIME_BITS-1:0]         cur_begin;
	logic [TIME_BITS-1:0]         cur_end;
	logic                         cur_gate;
	logic [TIME_BITS-1:0]         last_time;
	logic signed [VALUE_BITS-1:0] last_value;
	logic                         have_last;

	crossing_t pending_edges[$];
	int        errors = 0;
	int        samples_sent = 0;
	int        edges_seen = 0;
	int        snd_gap_max = 8;
	int        rcv_gap_max = 8;
	bit        hold_req = 1'b0;
	int        cycles = 0;

	level_crossing_edge_timer i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Timing model: works out the edge caused by one accepted sample, if any.
	function automatic bit time_crossing(input logic [TIME_BITS-1:0] t1,
			input logic signed [VALUE_BITS-1:0] v1, input logic first,
			output crossing_t found);
		logic [TIME_BITS-1:0] t0;
		longint v0, vn, lv;
		logic [127:0] num, den, prod, t;
		bit had, up, down;
		t0 = last_time;
		v0 = last_value;
		vn = v1;
		lv = cur_level;
		had = have_last && !first;
		last_time = t1;
		last_value = v1;
		have_last = 1'b1;
		found = '0;
		if (!had || cur_begin > cur_end || t1 < cur_begin || t1 > cur_end)
			return 1'b0;
		up = v0 < lv && vn >= lv;
		down = v0 >= lv && vn < lv;
		if (!up && !down)
			return 1'b0;
		t = t1;
		// Interpolate only in analog mode and when time did not run backwards.
		if (!cur_gate && t1 >= t0) begin
			num = up ? lv - v0 : v0 - lv;
			den = up ? vn - v0 : v0 - vn;
			prod = num * (t1 - t0);
			t = t0 + prod / den;
		end
		if (t < cur_begin || t > cur_end)
			return 1'b0;
		found.when = t[TIME_BITS-1:0];
		found.up = up;
		return 1'b1;
	endfunction

	function automatic logic [TIME_BITS-1:0] rand48();
		logic [63:0] r;
		r = {$urandom(), $urandom()};
		return r[TIME_BITS-1:0];
	endfunction

	// A value just above or below the current level, or at a value extreme.
	function automatic logic [VALUE_BITS-1:0] near_level(input bit above, input int cls);
		longint a, v;
		case (cls)
			0: a = $urandom_range(0, 3);
			1: a = $urandom_range(0, 1000);
			2: a = $urandom_range(0, 1 << 20);
			3: a = $urandom();
			default: a = 0;
		endcase
		if (cls == 4)
			return above ? V_MAX : V_MIN;
		v = above ? longint'(cur_level) + a : longint'(cur_level) - 1 - a;
		if (v > V_HI)
			v = V_HI;
		if (v < V_LO)
			v = V_LO;
		return v[VALUE_BITS-1:0];
	endfunction

	// Start of a record: mostly inside the window, sometimes just before it.
	function automatic logic [TIME_BITS-1:0] start_time();
		logic [63:0] span, r;
		if (cur_begin > cur_end)
			return rand48();
		span = 64'(cur_end) - 64'(cur_begin) + 1;
		r = {$urandom(), $urandom()};
		case ($urandom_range(0, 3))
			0: r = 64'(cur_begin) - $urandom_range(0, 100);
			1, 2: r = 64'(cur_begin) + 64'($urandom_range(0, 1000)) % span;
			default: r = 64'(cur_begin) + r % span;
		endcase
		return r[TIME_BITS-1:0];
	endfunction

	// Time advance within a record; the largest steps can wrap and run backwards.
	function automatic logic [63:0] step_size();
		int r;
		r = $urandom_range(0, 15);
		if (r < 3)
			return 64'd0;
		if (r < 8)
			return $urandom_range(1, 16);
		if (r < 12)
			return $urandom_range(1, 65535);
		if (r < 15)
			return 64'($urandom());
		return 64'(rand48());
	endfunction

	// Offer one sample and hold it until the block takes the transfer.
	task automatic offer(input logic [TIME_BITS-1:0] t, input logic [VALUE_BITS-1:0] v,
			input logic first);
		int gap;
		gap = $urandom_range(0, snd_gap_max);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tdata <= {v, t};
		s_tuser <= first;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic offer_and_predict(input logic [TIME_BITS-1:0] t,
			input logic [VALUE_BITS-1:0] v, input logic first);
		crossing_t c;
		offer(t, v, first);
		samples_sent++;
		if (time_crossing(t, v, first, c))
			pending_edges = {pending_edges, c};
	endtask

	// Stop sending and let every expected edge out, plus the divider's tail.
	task automatic settle();
		s_tvalid <= 1'b0;
		while (pending_edges.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_BITS-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		case (idx)
			REG_LEVEL:     cur_level = data[VALUE_BITS-1:0];
			REG_WIN_BEGIN: cur_begin = data[TIME_BITS-1:0];
			REG_WIN_END:   cur_end = data[TIME_BITS-1:0];
			REG_GATE_MODE: cur_gate = data[0];
		endcase
	endtask

	// Writes all four registers; level and gate carry junk above their width.
	task automatic apply_setting(input logic [VALUE_BITS-1:0] lvl,
			input logic [TIME_BITS-1:0] wb, input logic [TIME_BITS-1:0] we,
			input logic gm);
		logic [CFG_BITS-1:0] junk;
		junk = rand48();
		write_reg(REG_LEVEL, {junk[CFG_BITS-1:VALUE_BITS], lvl});
		write_reg(REG_WIN_BEGIN, wb);
		write_reg(REG_WIN_END, we);
		write_reg(REG_GATE_MODE, {junk[CFG_BITS-1:1], gm});
		cfg_we <= 1'b0;
	endtask

	// Random part: mostly well-formed records around the level, some noise.
	task automatic run_records(input int count);
		int sent, len, k, acls;
		logic [63:0] tcur;
		bit above;
		sent = 0;
		while (sent < count) begin
			if ($urandom_range(0, 9) == 0) begin
				offer_and_predict(rand48(), $urandom(), $urandom_range(0, 1));
				sent++;
			end else begin
				len = $urandom_range(2, 12);
				acls = $urandom_range(0, 4);
				tcur = start_time();
				above = $urandom_range(0, 1);
				for (k = 0; k < len && sent < count; k++) begin
					if (k > 0)
						tcur = tcur + step_size();
					if ($urandom_range(0, 1) == 1)
						above = !above;
					offer_and_predict(tcur[TIME_BITS-1:0], near_level(above, acls),
						k == 0 ? ($urandom_range(0, 7) != 0) : 1'b0);
					sent++;
				end
			end
		end
	endtask

	// Edge checker: every transfer must match the oldest expected crossing.
	always @(posedge clk) begin
		crossing_t want;
		if (arst_n && m_tvalid && m_tready) begin
			edges_seen++;
			if (pending_edges.size() == 0) begin
				errors++;
				if (errors <= 40)
					$display("%0t: unexpected edge, edge_time expected none got %h",
						$time, m_tdata[TIME_BITS-1:0]);
			end else begin
				want = pending_edges.pop_front();
				if (m_tdata[TIME_BITS-1:0] !== want.when) begin
					errors++;
					if (errors <= 40)
						$display("%0t: edge_time expected %h got %h", $time, want.when,
							m_tdata[TIME_BITS-1:0]);
				end
				if (m_tuser !== want.up) begin
					errors++;
					if (errors <= 40)
						$display("%0t: rising expected %b got %b", $time, want.up,
							m_tuser);
				end
			end
		end
	end

	// Edge receiver: random back-pressure, and one long hold-off on request.
	initial begin : edge_sink
		int gap;
		m_tready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			gap = $urandom_range(0, rcv_gap_max);
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!(m_tvalid && m_tready));
		end
	end

	// Watchdog on the total cycle count.
	initial begin : watchdog
		while (cycles < LIMIT_CYCLES) begin
			@(posedge clk);
			cycles++;
		end
		$display("testbench: errors");
		$finish;
	end

	// Main sequence: reset, directed table, then the random settings.
	initial begin : stimulus
		dir_row_t row;
		crossing_t c;
		bit hit;
		logic [63:0] span_end;
		logic [TIME_BITS-1:0] wb;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_LEVEL;
		cfg_data <= '0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= 1'b0;
		cur_level = '0;
		cur_begin = '0;
		cur_end = T_MAX;
		cur_gate = 1'b0;
		last_time = '0;
		last_value = '0;
		have_last = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < $size(DIR_TAB); i++) begin
			row = DIR_TAB[i];
			if (row.kind == ROW_WRITE) begin
				settle();
				write_reg(row.idx, row.t);
				cfg_we <= 1'b0;
			end else begin
				offer(row.t, row.v, row.first);
				samples_sent++;
				hit = time_crossing(row.t, row.v, row.first, c);
				// Typed rows take their edge from the table instead of the model.
				if (row.typed) begin
					hit = row.hit;
					c.when = row.et;
					c.up = row.up;
				end
				if (hit)
					pending_edges = {pending_edges, c};
			end
		end

		for (int setting = 0; setting < SETTINGS_N; setting++) begin
			settle();
			case (setting)
				0: apply_setting('0, '0, T_MAX, 1'b0);
				1: apply_setting(V_MIN, '0, T_MAX, 1'b0);
				2: apply_setting(V_MAX, '0, T_MAX, 1'b1);
				3: apply_setting(32'd1, '0, T_MAX, 1'b1);
				4: begin
					// Narrow window somewhere in the time range.
					wb = rand48();
					span_end = 64'(wb) + $urandom_range(0, 1 << 30);
					if (span_end > 64'(T_MAX))
						span_end = 64'(T_MAX);
					apply_setting($urandom(), wb, span_end[TIME_BITS-1:0], 1'b0);
				end
				5: begin
					// Empty window: begin one past end.
					wb = rand48() | 48'd1;
					apply_setting($urandom(), wb, wb - 1, $urandom_range(0, 1));
				end
				6: apply_setting($urandom(), '0, '0, 1'b0);
				7: apply_setting($urandom(), T_MAX, T_MAX, $urandom_range(0, 1));
				default: apply_setting($urandom(),
					$urandom_range(0, 1) ? 48'd0 : rand48() >> 4, T_MAX,
					$urandom_range(0, 1));
			endcase
			snd_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 8;
			rcv_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 8;
			// Back-to-back samples against a stalled receiver fill the job queue.
			if (setting == HOLD_SETTING) begin
				snd_gap_max = 0;
				hold_req = 1'b1;
			end
			run_records(ITEMS_PER);
		end
		settle();

		$display("summary: %0d samples sent, %0d edges checked, %0d random settings",
			samples_sent, edges_seen, SETTINGS_N);
		$display("summary: analog and gate timing, empty and narrow windows, level extremes");
		if (errors == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule
